### rtl/tfst_pkg.sv
// ----------------------------------------------------------------------------
// tfst_pkg: shared types and function of the tcp flow state tracker
// Holds the flow record layout, the opcodes, the tcp states and the
// per-direction state transition function.
// ----------------------------------------------------------------------------
package tfst_pkg;

    localparam int FLOW_COUNT_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    // tcp flag bit positions
    localparam int FL_FIN = 0;
    localparam int FL_SYN = 1;
    localparam int FL_RST = 2;
    localparam int FL_ACK = 4;

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_EXPIRE = 2'd1,
        OP_OPEN   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_NONE        = 3'd0,
        ST_SYN_SENT    = 3'd1,
        ST_SYN_RECV    = 3'd2,
        ST_ESTABLISHED = 3'd3,
        ST_FIN_WAIT1   = 3'd4,
        ST_FIN_WAIT2   = 3'd5,
        ST_TIME_WAIT   = 3'd6,
        ST_CLOSED      = 3'd7
    } t_tcp_state;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] pkts;
        logic [63:0] bytes;
    } t_dir_rec;

    // one memory row per flow; dir[1] is toward server, dir[0] toward client
    typedef struct packed {
        t_tcp_state       srv_state;
        t_tcp_state       cli_state;
        logic [31:0]      last_seen;
        logic [31:0]      start;
        t_dir_rec [1:0]   dir;
    } t_flow_rec;

    typedef struct packed {
        t_opcode     opcode;
        logic        to_server;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] len;
        logic [31:0] now;
    } t_item;

    typedef struct packed {
        t_tcp_state  srv_state;
        t_tcp_state  cli_state;
        logic        expired;
        logic [31:0] pkts;
        logic [63:0] bytes;
    } t_result;

    function automatic t_tcp_state next_state(t_tcp_state st, logic [7:0] flags);
        t_tcp_state ns;
        ns = st;
        case (st)
            ST_NONE:        if (flags[FL_SYN]) ns = ST_SYN_SENT;
            ST_SYN_SENT:    if (flags[FL_SYN] || flags[FL_ACK]) ns = ST_SYN_RECV;
            ST_SYN_RECV:    if (flags[FL_ACK]) ns = ST_ESTABLISHED;
            ST_ESTABLISHED: begin
                if (flags[FL_FIN]) ns = ST_FIN_WAIT1;
                else if (flags[FL_RST]) ns = ST_CLOSED;
            end
            ST_FIN_WAIT1:   if (flags[FL_ACK]) ns = ST_FIN_WAIT2;
            ST_FIN_WAIT2:   if (flags[FL_FIN]) ns = ST_TIME_WAIT;
            ST_TIME_WAIT:   ns = st;
            ST_CLOSED:      ns = st;
            default:        ns = st;
        endcase
        return ns;
    endfunction

endpackage

### rtl/tfst_ram.sv
// ----------------------------------------------------------------------------
// tfst_ram: generic single-clock ram
// One write port and one read port, registered read data, read-first on a
// same-address collision.
// ----------------------------------------------------------------------------
module tfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tfst_update.sv
// ----------------------------------------------------------------------------
// tfst_update: flow record update
// Applies one request to a flow record: packet update, expiry check or open,
// and forms the result fields.
// ----------------------------------------------------------------------------
module tfst_update (
    input  tfst_pkg::t_item     i_item,
    input  tfst_pkg::t_flow_rec i_rec,
    input  logic [31:0]         i_timeout,
    output tfst_pkg::t_flow_rec o_rec,
    output tfst_pkg::t_result   o_res
);
    import tfst_pkg::*;

    logic [31:0] w_idle;
    t_flow_rec   w_rec;
    logic        w_expired;

    assign w_idle = i_item.now - i_rec.last_seen;

    always_comb begin
        w_rec     = i_rec;
        w_expired = 1'b0;
        case (i_item.opcode)
            OP_PACKET: begin
                w_rec.dir[i_item.to_server].seq   = i_item.seq;
                w_rec.dir[i_item.to_server].ack   = i_item.ack;
                w_rec.dir[i_item.to_server].pkts  = i_rec.dir[i_item.to_server].pkts + 32'd1;
                w_rec.dir[i_item.to_server].bytes = i_rec.dir[i_item.to_server].bytes
                                                  + 64'(i_item.len);
                if (i_item.to_server) begin
                    w_rec.srv_state = next_state(i_rec.srv_state, i_item.flags);
                end else begin
                    w_rec.cli_state = next_state(i_rec.cli_state, i_item.flags);
                end
                w_rec.last_seen = i_item.now;
            end
            OP_EXPIRE: begin
                if (w_idle > i_timeout) begin
                    w_rec     = '0;
                    w_expired = 1'b1;
                end
            end
            OP_OPEN: begin
                w_rec           = '0;
                w_rec.start     = i_item.now;
                w_rec.last_seen = i_item.now;
            end
            default: begin
                w_rec = i_rec;
            end
        endcase
    end

    assign o_rec           = w_rec;
    assign o_res.srv_state = w_rec.srv_state;
    assign o_res.cli_state = w_rec.cli_state;
    assign o_res.expired   = w_expired;
    assign o_res.pkts      = w_rec.dir[i_item.to_server].pkts;
    assign o_res.bytes     = w_rec.dir[i_item.to_server].bytes;

endmodule

### rtl/tcp_flow_state_tracker.sv
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker: per-flow tcp state and counter table
// Flow records live in one ram row per flow; each request reads its row,
// updates it and writes it back when the update stage completes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          carries
//  --------  ---------  -----------------  ---------------------------------
//  in        input      i_in_valid/o_in_stall   opcode, flow, flags, seq, ack,
//                                          length, time
//  out       output     o_out_valid/i_out_stall result flow, states, expired,
//                                          counters
//  cfg       input      i_cfg_valid/o_cfg_ready flow_timeout write data
//
//  - a request is read from the ram at the accept edge, then updated and
//    written back at the edge at which the update stage completes, which
//    also raises o_out_valid; one request per cycle is sustained while the
//    output drains
//  - a request to the same flow right behind another takes the updated row
//    from a forward register instead of the ram
//  - after reset a clearing pass writes FLOW_COUNT zero rows, one per cycle;
//    o_in_stall stays high meanwhile, cfg writes are taken as usual
//  - a stalled output holds the update stage, which then stalls the input
//
module tcp_flow_state_tracker #(
    parameter int FLOW_COUNT = tfst_pkg::FLOW_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_flow_index,
    input  logic        i_to_server,
    input  logic [7:0]  i_tcp_flags,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_ack_number,
    input  logic [15:0] i_packet_length,
    input  logic [31:0] i_now_ticks,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_result_flow,
    output logic [2:0]  o_state_toward_server,
    output logic [2:0]  o_state_toward_client,
    output logic        o_expired,
    output logic [31:0] o_direction_packets,
    output logic [63:0] o_direction_bytes,
    // timeout register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import tfst_pkg::*;

    localparam int IW     = $clog2(FLOW_COUNT);
    localparam int REC_W  = $bits(t_flow_rec);
    localparam int IDX_MAX = (1 << IDX_W) - 1;

    // control state
    logic          r_clearing;
    logic [IW-1:0] r_clr_addr;
    logic          r_b_valid;
    logic          r_fwd;
    logic          r_out_valid;
    logic [31:0]   r_timeout;

    // payload state
    t_item         r_b_item;
    logic [IW-1:0] r_b_idx;
    t_flow_rec     r_fwd_row;
    logic [9:0]    r_out_flow;
    t_result       r_out_res;

    logic [9:0]    w_red;
    logic [IW-1:0] w_idx;
    logic          w_accept;
    logic          w_b_go;
    t_item         w_item;
    logic [REC_W-1:0] w_rdata;
    t_flow_rec     w_row;
    t_flow_rec     w_new_row;
    t_result       w_res;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [REC_W-1:0] w_wdata;

    // flow index modulo FLOW_COUNT by restoring subtraction of shifted counts
    always_comb begin
        w_red = i_flow_index;
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if ((FLOW_COUNT << k) <= IDX_MAX) begin
                if (w_red >= 10'(FLOW_COUNT << k)) begin
                    w_red = w_red - 10'(FLOW_COUNT << k);
                end
            end
        end
    end

    assign w_idx = IW'(w_red);

    // update stage completes when the output register is free or draining
    assign w_b_go     = r_b_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_b_valid && !w_b_go);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_item.opcode    = t_opcode'(i_opcode);
        w_item.to_server = i_to_server;
        w_item.flags     = i_tcp_flags;
        w_item.seq       = i_seq_number;
        w_item.ack       = i_ack_number;
        w_item.len       = i_packet_length;
        w_item.now       = i_now_ticks;
    end

    // ram write port: clearing pass or update write-back
    assign w_we    = r_clearing || w_b_go;
    assign w_waddr = r_clearing ? r_clr_addr : r_b_idx;
    assign w_wdata = r_clearing ? '0 : REC_W'(w_new_row);

    tfst_ram #(
        .WIDTH (REC_W),
        .DEPTH (FLOW_COUNT),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    // row written at the read edge is taken from the forward register
    assign w_row = r_fwd ? r_fwd_row : t_flow_rec'(w_rdata);

    tfst_update u_update (
        .i_item    (r_b_item),
        .i_rec     (w_row),
        .i_timeout (r_timeout),
        .o_rec     (w_new_row),
        .o_res     (w_res)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_b_valid   <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IW'(FLOW_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_accept) begin
                r_b_valid <= 1'b1;
                r_fwd     <= w_b_go && (r_b_idx == w_idx);
            end else if (w_b_go) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_item  <= w_item;
            r_b_idx   <= w_idx;
            r_fwd_row <= w_new_row;
        end
        if (w_b_go) begin
            r_out_flow <= 10'(r_b_idx);
            r_out_res  <= w_res;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_result_flow         = r_out_flow;
    assign o_state_toward_server = r_out_res.srv_state;
    assign o_state_toward_client = r_out_res.cli_state;
    assign o_expired             = r_out_res.expired;
    assign o_direction_packets   = r_out_res.pkts;
    assign o_direction_bytes     = r_out_res.bytes;

endmodule
